// ===== rtl/mbrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus read request framer package
// Shared constants, register indexes and the CRC-16/MODBUS byte step.
// ----------------------------------------------------------------------------
package mbrf_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAME_LEN = 8;
    localparam int BEAT_W = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [2:0] COUNT_MAX = 3'd7;
    localparam logic [2:0] COUNT_DIST_HIGH = 3'd3;
    localparam logic [2:0] COUNT_DIST_LOW = 3'd4;

    localparam logic [7:0] SLAVE_ADDRESS_RST = 8'd80;
    localparam logic [7:0] FUNCTION_CODE_RST = 8'd3;
    localparam logic [15:0] START_REGISTER_RST = 16'd52;
    localparam logic [15:0] WORD_COUNT_RST = 16'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_REGISTER = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_COUNT = 2'd3;

    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_REPLY = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DISTANCE = 1'b1;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        int b;
        c = crc_in ^ {8'h00, data};
        for (b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/modbus_read_request_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus read request framer
// Emits an 8-byte Modbus RTU read frame with CRC per request item and
// extracts a 16-bit distance from reply bytes 3 and 4.
// ----------------------------------------------------------------------------
// The first result passes the input hold register and then the output register.
// Throughput: one frame byte per cycle, the CRC advanced alongside, and one reply
// item per cycle, each only while the output is not stalled.
// Reset: configuration returns to its defaults, the reply counter and held
// distance byte clear, and both channels come up empty.
module modbus_read_request_framer
    import mbrf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                   s_axis_tuser,   // [0] req_type
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]        m_axis_tdata,   // [7:0] tx_byte, [23:8] distance_mm
    output logic                        m_axis_tuser,   // [0] out_kind
    output logic                        m_axis_tlast    // last
);

    logic [7:0]  slave_address_reg;
    logic [7:0]  function_code_reg;
    logic [15:0] start_register_reg;
    logic [15:0] word_count_reg;

    logic              hold_valid_reg;
    logic              hold_req_reg;
    logic [7:0]        hold_rx_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [15:0]       crc_reg;
    logic [2:0]        reply_count_reg;
    logic [7:0]        dist_high_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_kind_reg;
    logic                 out_last_reg;

    logic                 in_accept;
    logic                 res_valid;
    logic                 out_load;
    logic                 item_done;
    logic                 is_request;
    logic [7:0]           frame_byte;
    logic [15:0]          crc_next;
    logic [M_TDATA_W-1:0] res_data;
    logic                 res_kind;
    logic                 res_last;

    assign is_request = hold_req_reg == REQ_SEND;

    always_comb
    begin
        unique case (beat_reg)
            3'd0: frame_byte = slave_address_reg;
            3'd1: frame_byte = function_code_reg;
            3'd2: frame_byte = start_register_reg[15:8];
            3'd3: frame_byte = start_register_reg[7:0];
            3'd4: frame_byte = word_count_reg[15:8];
            3'd5: frame_byte = word_count_reg[7:0];
            3'd6: frame_byte = crc_reg[7:0];
            3'd7: frame_byte = crc_reg[15:8];
            default: frame_byte = 8'h00;
        endcase
    end

    assign crc_next = crc_byte((beat_reg == '0) ? CRC_INIT : crc_reg, frame_byte);

    always_comb
    begin
        if (is_request)
        begin
            res_valid = hold_valid_reg;
            res_kind  = KIND_FRAME;
            res_data  = {16'h0000, frame_byte};
            res_last  = beat_reg == BEAT_W'(FRAME_LEN - 1);
        end
        else
        begin
            res_valid = hold_valid_reg && (reply_count_reg == COUNT_DIST_LOW);
            res_kind  = KIND_DISTANCE;
            res_data  = {dist_high_reg, hold_rx_reg, 8'h00};
            res_last  = 1'b1;
        end
    end

    assign out_load      = res_valid && (!out_valid_reg || m_axis_tready);
    assign item_done     = hold_valid_reg && (res_valid ? (out_load && res_last) : 1'b1);
    assign s_axis_tready = !hold_valid_reg || item_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg  <= SLAVE_ADDRESS_RST;
            function_code_reg  <= FUNCTION_CODE_RST;
            start_register_reg <= START_REGISTER_RST;
            word_count_reg     <= WORD_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS:  slave_address_reg  <= cfg_wdata[7:0];
                REG_FUNCTION_CODE:  function_code_reg  <= cfg_wdata[7:0];
                REG_START_REGISTER: start_register_reg <= cfg_wdata;
                REG_WORD_COUNT:     word_count_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            beat_reg        <= '0;
            reply_count_reg <= '0;
            dist_high_reg   <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (item_done)
            begin
                beat_reg <= '0;
            end
            else if (out_load && is_request)
            begin
                beat_reg <= beat_reg + 1'b1;
            end

            if (item_done)
            begin
                if (is_request)
                begin
                    reply_count_reg <= '0;
                end
                else
                begin
                    if (reply_count_reg == COUNT_DIST_HIGH)
                    begin
                        dist_high_reg <= hold_rx_reg;
                    end
                    if (reply_count_reg != COUNT_MAX)
                    begin
                        reply_count_reg <= reply_count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_req_reg <= s_axis_tuser;
            hold_rx_reg  <= s_axis_tdata[7:0];
        end
        if (out_load && is_request && (beat_reg < BEAT_W'(FRAME_LEN - 2)))
        begin
            crc_reg <= crc_next;
        end
        if (out_load)
        begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/mbrf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus read request framer checker
// Port-level properties of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module mbrf_checker
    import mbrf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_distance_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DISTANCE) |->
            m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
        else $error("distance item not alone or tx byte not clear");

    a_frame_no_distance: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FRAME) |->
            m_axis_tdata[23:8] == 16'h0000)
        else $error("frame byte item carries distance bits");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_FRAME) &&
            !m_axis_tlast |=> m_axis_tvalid && (m_axis_tuser == KIND_FRAME))
        else $error("frame byte sequence broken");

endmodule

bind modbus_read_request_framer mbrf_checker u_mbrf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
